// ----- rtl/core/sensor_frame_crc_check_convert_core_macros.svh -----
// assertion helpers, sampled on clk and held off during reset
`ifndef SENSOR_FRAME_CRC_CHECK_CONVERT_CORE_MACROS_SVH
`define SENSOR_FRAME_CRC_CHECK_CONVERT_CORE_MACROS_SVH

// same-cycle implication
`define SFCC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SFCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/sfcc_pkg.sv -----
package sfcc_pkg;

    localparam int DATA_W = 8;
    localparam int RAW_W  = 16;
    localparam int TEMP_W = 12;
    localparam int HUM_W  = 10;

    localparam logic [DATA_W-1:0] CRC_POLY = 8'h31;
    localparam logic [DATA_W-1:0] CRC_INIT = 8'hFF;

    localparam int FULL_SCALE         = 65535;
    localparam int TEMP_SPAN_TENTHS   = 1750;
    localparam int TEMP_OFFSET_TENTHS = 450;
    localparam int HUM_SPAN_TENTHS    = 1000;
    localparam int TEMP_OFFSET_SCALED = TEMP_OFFSET_TENTHS * FULL_SCALE;

    // raw temperature word that converts to zero tenths
    localparam logic [RAW_W-1:0] TEMP_RAW_ZERO = 16'd16852;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TEMP_FAIL = 2'd1,
        ST_HUM_FAIL  = 2'd2
    } status_t;

    function automatic logic [DATA_W-1:0] crc_byte(input logic [DATA_W-1:0] crc,
                                                   input logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] c;
        c = crc ^ b;
        for (int k = 0; k < DATA_W; k++)
        begin
            if (c[DATA_W-1])
            begin
                c = {c[DATA_W-2:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[DATA_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/core/sfcc_ifs.sv -----
interface sfcc_byte_if;
    logic                         valid;
    logic                         ready;
    logic [sfcc_pkg::DATA_W-1:0]  data_byte;
    logic                         frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface sfcc_reading_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         status;
    logic signed [sfcc_pkg::TEMP_W-1:0] temperature_tenths;
    logic [sfcc_pkg::HUM_W-1:0]         humidity_tenths;

    modport source (output valid, output status, output temperature_tenths,
                    output humidity_tenths, input ready);
    modport sink   (input valid, input status, input temperature_tenths,
                    input humidity_tenths, output ready);
endinterface

// ----- rtl/core/sensor_frame_crc_check_convert_core.sv -----
// channel       dir  beat
// frame_bytes   in   one frame byte (data_byte, frame_start)
// readings      out  status, temperature_tenths, humidity_tenths, one per frame
//
// one byte is taken every cycle while frame_bytes.ready is high; the crc and frame state update at the byte beat
// a reading is built at the sixth byte and leaves through a 5-stage scaling pipe
// the pipe stages each hold one frame, so stalls on readings fill them before
// frame_bytes.ready drops
// rst_n clears position, failure flag, humidity word and stage valids; crc to CRC_INIT, held temp to TEMP_RAW_ZERO
`include "sensor_frame_crc_check_convert_core_macros.svh"

module sensor_frame_crc_check_convert_core (
    input  logic                  clk,
    input  logic                  rst_n,
    sfcc_byte_if.sink             frame_bytes,
    sfcc_reading_if.source        readings
);
    import sfcc_pkg::*;

    localparam logic [2:0] POS_T_HI  = 3'd0;
    localparam logic [2:0] POS_T_LO  = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_HI  = 3'd3;
    localparam logic [2:0] POS_H_LO  = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    localparam int PROD_T_W = 27;
    localparam int PROD_H_W = 26;

    // frame state
    logic [2:0]        pos_reg;
    logic [DATA_W-1:0] crc_reg;
    logic [RAW_W-1:0]  raw_reg;
    logic              tfail_reg;
    logic [RAW_W-1:0]  traw_held_reg;
    logic [RAW_W-1:0]  hraw_held_reg;

    // pipe stages
    logic                     v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    status_t                  st1_reg, st2_reg, st3_reg, st4_reg, st5_reg;
    logic [RAW_W-1:0]         tr1_reg, hr1_reg;
    logic signed [PROD_T_W:0] nt2_reg;
    logic [PROD_H_W-1:0]      nh2_reg, nh3_reg, nh4_reg;
    logic                     tneg3_reg, tneg4_reg;
    logic [PROD_T_W-1:0]      mt3_reg, mt4_reg;
    logic [TEMP_W-1:0]        qt4_reg;
    logic [HUM_W:0]           qh4_reg;
    logic signed [TEMP_W-1:0] temp5_reg;
    logic [HUM_W-1:0]         hum5_reg;

    logic en1, en2, en3, en4, en5;
    logic in_fire;
    logic [2:0] pos;
    logic [DATA_W-1:0] crc_base, crc_new;
    logic crc_match;
    logic fire_last;

    logic [PROD_T_W-1:0] prod_t;
    logic [PROD_H_W-1:0] prod_h;
    logic [PROD_T_W:0]   tsum;
    logic [PROD_H_W:0]   hsum;
    logic [TEMP_W-1:0]   tq_inc, tq;
    logic [PROD_T_W:0]   tbound;
    logic [HUM_W:0]      hq_inc, hq;
    logic [PROD_H_W:0]   hbound;

    assign en5 = !v5_reg || readings.ready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign frame_bytes.ready = en1;
    assign in_fire = frame_bytes.valid && frame_bytes.ready;

    always_comb
    begin
        pos = frame_bytes.frame_start ? POS_T_HI : pos_reg;
        if (pos > POS_H_CRC)
        begin
            pos = POS_T_HI;
        end
    end

    assign crc_base  = (pos == POS_T_HI || pos == POS_H_HI) ? CRC_INIT : crc_reg;
    assign crc_new   = crc_byte(crc_base, frame_bytes.data_byte);
    assign crc_match = (crc_reg == frame_bytes.data_byte);
    assign fire_last = in_fire && (pos == POS_H_CRC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_T_HI;
            crc_reg       <= CRC_INIT;
            raw_reg       <= '0;
            tfail_reg     <= 1'b0;
            traw_held_reg <= TEMP_RAW_ZERO;
            hraw_held_reg <= '0;
        end
        else if (in_fire)
        begin
            unique case (pos)
                POS_T_HI, POS_H_HI:
                begin
                    crc_reg <= crc_new;
                    raw_reg <= {{(RAW_W-DATA_W){1'b0}}, frame_bytes.data_byte};
                    pos_reg <= pos + 3'd1;
                end
                POS_T_LO, POS_H_LO:
                begin
                    crc_reg <= crc_new;
                    raw_reg <= {raw_reg[DATA_W-1:0], frame_bytes.data_byte};
                    pos_reg <= pos + 3'd1;
                end
                POS_T_CRC:
                begin
                    if (crc_match)
                    begin
                        tfail_reg     <= 1'b0;
                        traw_held_reg <= raw_reg;
                    end
                    else
                    begin
                        tfail_reg <= 1'b1;
                    end
                    crc_reg <= CRC_INIT;
                    pos_reg <= POS_H_HI;
                end
                default:
                begin
                    if (!tfail_reg && crc_match)
                    begin
                        hraw_held_reg <= raw_reg;
                    end
                    crc_reg <= CRC_INIT;
                    pos_reg <= POS_T_HI;
                end
            endcase
        end
    end

    // pipe valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= fire_last;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    assign prod_t = PROD_T_W'(tr1_reg) * PROD_T_W'(TEMP_SPAN_TENTHS);
    assign prod_h = PROD_H_W'(hr1_reg) * PROD_H_W'(HUM_SPAN_TENTHS);

    // divide by full scale: estimate from (m + m/2^16)/2^16, then one correction
    assign tsum = (PROD_T_W+1)'(mt3_reg) + (PROD_T_W+1)'(mt3_reg[PROD_T_W-1:16]);
    assign hsum = (PROD_H_W+1)'(nh3_reg) + (PROD_H_W+1)'(nh3_reg[PROD_H_W-1:16]);

    assign tq_inc = qt4_reg + TEMP_W'(1);
    assign tbound = {tq_inc, 16'b0} - (PROD_T_W+1)'(tq_inc);
    assign tq     = ((PROD_T_W+1)'(mt4_reg) >= tbound) ? tq_inc : qt4_reg;

    assign hq_inc = qh4_reg + (HUM_W+1)'(1);
    assign hbound = {hq_inc, 16'b0} - (PROD_H_W+1)'(hq_inc);
    assign hq     = ((PROD_H_W+1)'(nh4_reg) >= hbound) ? hq_inc : qh4_reg;

    // pipe payload
    always_ff @(posedge clk)
    begin
        if (en1 && fire_last)
        begin
            if (tfail_reg)
            begin
                st1_reg <= ST_TEMP_FAIL;
                hr1_reg <= hraw_held_reg;
            end
            else if (crc_match)
            begin
                st1_reg <= ST_OK;
                hr1_reg <= raw_reg;
            end
            else
            begin
                st1_reg <= ST_HUM_FAIL;
                hr1_reg <= hraw_held_reg;
            end
            tr1_reg <= traw_held_reg;
        end
        if (en2 && v1_reg)
        begin
            st2_reg <= st1_reg;
            nt2_reg <= $signed({1'b0, prod_t}) - $signed((PROD_T_W+1)'(TEMP_OFFSET_SCALED));
            nh2_reg <= prod_h;
        end
        if (en3 && v2_reg)
        begin
            st3_reg   <= st2_reg;
            tneg3_reg <= nt2_reg[PROD_T_W];
            mt3_reg   <= nt2_reg[PROD_T_W] ? PROD_T_W'(-nt2_reg) : nt2_reg[PROD_T_W-1:0];
            nh3_reg   <= nh2_reg;
        end
        if (en4 && v3_reg)
        begin
            st4_reg   <= st3_reg;
            tneg4_reg <= tneg3_reg;
            mt4_reg   <= mt3_reg;
            qt4_reg   <= tsum[PROD_T_W:16];
            nh4_reg   <= nh3_reg;
            qh4_reg   <= hsum[PROD_H_W:16];
        end
        if (en5 && v4_reg)
        begin
            st5_reg   <= st4_reg;
            temp5_reg <= tneg4_reg ? -$signed(tq) : $signed(tq);
            hum5_reg  <= hq[HUM_W-1:0];
        end
    end

    assign readings.valid              = v5_reg;
    assign readings.status             = st5_reg;
    assign readings.temperature_tenths = temp5_reg;
    assign readings.humidity_tenths    = hum5_reg;

    `SFCC_ASSERT_NOW(a_pos_range, 1'b1, pos_reg <= POS_H_CRC, "frame position out of range")
    `SFCC_ASSERT_NOW(a_crc_fresh, pos_reg == POS_T_HI || pos_reg == POS_H_HI,
        crc_reg == CRC_INIT, "crc not restarted at word start")
    `SFCC_ASSERT_NEXT(a_last_enters_pipe, fire_last, v1_reg, "sixth byte did not enter pipe")
    `SFCC_ASSERT_NOW(a_hum_range, v5_reg, hum5_reg <= HUM_W'(HUM_SPAN_TENTHS),
        "humidity above full scale")
    `SFCC_ASSERT_NOW(a_temp_range, v5_reg,
        temp5_reg >= -12'sd450 && temp5_reg <= 12'sd1300, "temperature out of range")

endmodule
